/* design/pta_pkg.sv */
// Package for the pressure-to-altitude pipeline.
// Holds the fixed-point constants, coefficient table and stage control type.
// No dependencies.
`timescale 1ns / 1ps
package pta_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int PRES_W     = 17;
  localparam int ALT_W      = 19;
  localparam int QUO_W      = PRES_W + FRAC_BITS;
  localparam int DIV_CELLS  = QUO_W;
  localparam int WIDE_W     = 128;
  localparam int T_W        = 64;
  localparam int LIMB_W     = 32;
  localparam int LIMBS      = WIDE_W / LIMB_W;
  localparam int HORNER_CELLS = 5;
  localparam logic [15:0] ALT_SCALE = 16'd44330;
  localparam logic [PRES_W-1:0] REF_RESET = 17'd101325;
  localparam logic [63:0] DEC_SCALE = 64'd100000000;

  localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) << FRAC_BITS;

  localparam logic [63:0] MAG0 = (64'd2487306  << FRAC_BITS) / DEC_SCALE;
  localparam logic [63:0] MAG1 = (64'd3264262  << FRAC_BITS) / DEC_SCALE;
  localparam logic [63:0] MAG2 = (64'd4647467  << FRAC_BITS) / DEC_SCALE;
  localparam logic [63:0] MAG3 = (64'd7704150  << FRAC_BITS) / DEC_SCALE;
  localparam logic [63:0] MAG4 = (64'd19029497 << FRAC_BITS) / DEC_SCALE;

  // Addend of each Horner step; the initial value is COEF_INIT.
  localparam logic signed [WIDE_W-1:0] COEF_INIT = {64'd0, MAG0};
  localparam logic signed [WIDE_W-1:0] COEF_ADD [HORNER_CELLS] = '{
    -$signed({64'd0, MAG1}),
    $signed({64'd0, MAG2}),
    -$signed({64'd0, MAG3}),
    $signed({64'd0, MAG4}),
    ONE
  };

  typedef struct packed {
    logic valid;
    logic zero;
  } stage_ctl_t;

endpackage

/* design/pta_div_cell.sv */
// One restoring-division cell: resolves one quotient bit per transaction.
// Depends on pta_pkg.
`timescale 1ns / 1ps
module pta_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  pta_pkg::stage_ctl_t           ctl_in,
  input  logic [pta_pkg::PRES_W-1:0]    div_in,
  input  logic [pta_pkg::PRES_W-1:0]    rem_in,
  input  logic [pta_pkg::QUO_W-1:0]     num_in,
  input  logic [pta_pkg::QUO_W-1:0]     quo_in,
  output pta_pkg::stage_ctl_t           ctl_out,
  output logic [pta_pkg::PRES_W-1:0]    div_out,
  output logic [pta_pkg::PRES_W-1:0]    rem_out,
  output logic [pta_pkg::QUO_W-1:0]     num_out,
  output logic [pta_pkg::QUO_W-1:0]     quo_out
);
  import pta_pkg::*;

  logic [PRES_W:0]   trial;
  logic              take;
  logic [PRES_W-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, num_in[QUO_W-1]};
    take     = trial >= {1'b0, div_in};
    rem_next = take ? PRES_W'(trial - {1'b0, div_in}) : trial[PRES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      div_out <= div_in;
      rem_out <= rem_next;
      num_out <= {num_in[QUO_W-2:0], 1'b0};
      quo_out <= {quo_in[QUO_W-2:0], take};
    end
  end

endmodule

/* design/pta_horner_cell.sv */
// One Horner step in two stages: partial products, then sum, shift and add.
// Arithmetic wraps at 128 bits. Depends on pta_pkg.
`timescale 1ns / 1ps
module pta_horner_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [pta_pkg::WIDE_W-1:0]   coef,
  input  pta_pkg::stage_ctl_t                 ctl_in,
  input  logic signed [pta_pkg::T_W-1:0]      t_in,
  input  logic signed [pta_pkg::WIDE_W-1:0]   y_in,
  output pta_pkg::stage_ctl_t                 ctl_out,
  output logic signed [pta_pkg::T_W-1:0]      t_out,
  output logic signed [pta_pkg::WIDE_W-1:0]   y_out
);
  import pta_pkg::*;

  stage_ctl_t                ctl_a;
  logic signed [T_W-1:0]     t_a;
  logic [2*LIMB_W-1:0]       lo_pp [LIMBS];
  logic signed [2*LIMB_W+1:0] hi_pp [LIMBS];
  logic [WIDE_W-1:0]         acc;

  // Stage A: low half of t by each limb of y, signed high half by each limb.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
    end
    if (en) begin
      t_a <= t_in;
      for (int j = 0; j < LIMBS; j++) begin
        lo_pp[j] <= t_in[LIMB_W-1:0] * y_in[j*LIMB_W +: LIMB_W];
        hi_pp[j] <= $signed({t_in[T_W-1], t_in[T_W-1:LIMB_W]})
                  * $signed({1'b0, y_in[j*LIMB_W +: LIMB_W]});
      end
    end
  end

  // Stage B: sum partial products modulo 2^128.
  always_comb begin
    acc = '0;
    for (int j = 0; j < LIMBS; j++) begin
      acc = acc + ({{(WIDE_W-2*LIMB_W){1'b0}}, lo_pp[j]} << (LIMB_W*j));
      acc = acc + (WIDE_W'(hi_pp[j]) << (LIMB_W*(j+1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_a;
    end
    if (en) begin
      t_out <= t_a;
      y_out <= ($signed(acc) >>> FRAC_BITS) + coef;
    end
  end

endmodule

/* design/pta_scale.sv */
// Final scaling: altitude = floor(44330 * (1 - y) / 2^32), low bits only; zero when flagged.
// Two stages, the second is the output register. Depends on pta_pkg.
`timescale 1ns / 1ps
module pta_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  pta_pkg::stage_ctl_t                ctl_in,
  input  logic signed [pta_pkg::WIDE_W-1:0]  y_in,
  output pta_pkg::stage_ctl_t                ctl_out,
  output logic signed [pta_pkg::ALT_W-1:0]   alt_out
);
  import pta_pkg::*;

  stage_ctl_t         ctl_a;
  logic [63:0]        diff;
  logic [47:0]        m0;
  logic [47:0]        m1;
  logic [63:0]        prod;

  assign diff = 64'(ONE - y_in);
  assign prod = {16'd0, m0} + {m1[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a   <= ctl_in;
      ctl_out <= ctl_a;
    end
    if (en) begin
      m0      <= ALT_SCALE * diff[31:0];
      m1      <= ALT_SCALE * diff[63:32];
      alt_out <= ctl_a.zero ? '0 : $signed(prod[FRAC_BITS +: ALT_W]);
    end
  end

endmodule

/* design/pressure_to_altitude.sv */
// Pressure to barometric altitude, fully pipelined.
// Stages: 49 divider cells + 1 offset stage + 5 two-stage Horner cells + 2 scale
// stages, from acceptance to result valid. Throughput: one transaction
// per cycle; the whole pipeline advances together whenever the output is free.
// Reset (rst, synchronous): clears all stage valid bits, reference to 101325 Pa.
`timescale 1ns / 1ps
module pressure_to_altitude (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              reference_pressure_write,
  input  logic [pta_pkg::PRES_W-1:0]        reference_pressure,
  input  logic                              pressure_valid,
  output logic                              pressure_ready,
  input  logic [pta_pkg::PRES_W-1:0]        pressure,
  output logic                              altitude_valid,
  input  logic                              altitude_ready,
  output logic signed [pta_pkg::ALT_W-1:0]  altitude
);
  import pta_pkg::*;

  logic [PRES_W-1:0] ref_pressure;
  logic              en;

  stage_ctl_t        d_ctl [DIV_CELLS+1];
  logic [PRES_W-1:0] d_div [DIV_CELLS+1];
  logic [PRES_W-1:0] d_rem [DIV_CELLS+1];
  logic [QUO_W-1:0]  d_num [DIV_CELLS+1];
  logic [QUO_W-1:0]  d_quo [DIV_CELLS+1];

  stage_ctl_t               h_ctl [HORNER_CELLS+1];
  logic signed [T_W-1:0]    h_t   [HORNER_CELLS+1];
  logic signed [WIDE_W-1:0] h_y   [HORNER_CELLS+1];

  stage_ctl_t fin_ctl;

  // Advance every stage together unless a finished result is still held.
  assign en             = !altitude_valid || altitude_ready;
  assign pressure_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_pressure <= REF_RESET;
    end else if (reference_pressure_write) begin
      ref_pressure <= reference_pressure;
    end
  end

  // Feed the divider: dividend is pressure << FRAC_BITS, remainder starts at 0.
  // Zero pressure or zero reference forces the result to zero.
  assign d_ctl[0].valid = pressure_valid;
  assign d_ctl[0].zero  = (pressure == '0) || (ref_pressure == '0);
  assign d_div[0]       = ref_pressure;
  assign d_rem[0]       = '0;
  assign d_num[0]       = {pressure, {FRAC_BITS{1'b0}}};
  assign d_quo[0]       = '0;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    pta_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (d_ctl[i]),
      .div_in  (d_div[i]),
      .rem_in  (d_rem[i]),
      .num_in  (d_num[i]),
      .quo_in  (d_quo[i]),
      .ctl_out (d_ctl[i+1]),
      .div_out (d_div[i+1]),
      .rem_out (d_rem[i+1]),
      .num_out (d_num[i+1]),
      .quo_out (d_quo[i+1])
    );
  end

  // Form t = ratio - 1 in Q32 and load the initial Horner value.
  always_ff @(posedge clk) begin
    if (rst) begin
      h_ctl[0] <= '0;
    end else if (en) begin
      h_ctl[0] <= d_ctl[DIV_CELLS];
    end
    if (en) begin
      h_t[0] <= $signed({{(T_W-QUO_W){1'b0}}, d_quo[DIV_CELLS]}) - T_W'(ONE);
      h_y[0] <= COEF_INIT;
    end
  end

  for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_horner
    pta_horner_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .coef    (COEF_ADD[k]),
      .ctl_in  (h_ctl[k]),
      .t_in    (h_t[k]),
      .y_in    (h_y[k]),
      .ctl_out (h_ctl[k+1]),
      .t_out   (h_t[k+1]),
      .y_out   (h_y[k+1])
    );
  end

  // Scale to meters; the last stage is the output register.
  pta_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (h_ctl[HORNER_CELLS]),
    .y_in    (h_y[HORNER_CELLS]),
    .ctl_out (fin_ctl),
    .alt_out (altitude)
  );

  assign altitude_valid = fin_ctl.valid;

endmodule
